// ===== hdl/srtf_pkg.sv =====
// Shared constants, types and command/status bundles of the SRTF scheduler.
`default_nettype none

package srtf_pkg;

  localparam int MAX_PROCESSES_DEF = 16;
  localparam int TIME_BITS_DEF     = 16;

  localparam int NOW_W   = 21;
  localparam int SUM_W   = 25;
  localparam int DONE_W  = 5;
  localparam int PC_W    = 5;
  localparam int SLOT_W  = 4;
  localparam int CHOSEN_W = 4;

  localparam logic [NOW_W-1:0]  NOW_MAX   = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
  localparam logic [DONE_W-1:0] DONE_MAX  = '1;
  localparam logic [PC_W-1:0]   PC_RESET  = PC_W'(1);

  // opcode values carried in s_axis_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // register index of process_count
  localparam logic REG_PROCESS_COUNT = 1'b0;

  // output payload: tick_time, chosen, completion, turnaround, waiting,
  // total_waiting, total_turnaround, all_done
  localparam int OUT_FIELDS_W = 4 * NOW_W + CHOSEN_W + 2 * SUM_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic load;      // write a slot from the accepted transaction
    logic start;     // a tick transaction was accepted
    logic scan;      // issue scan read for the current slot
    logic pick;      // read stores at the chosen slot
    logic upd;       // decrement remaining, latch turnaround
    logic fin;       // compute waiting time
    logic sums;      // grow running totals and done count
    logic out_load;  // load the output register
  } cmd_t;

  typedef struct packed {
    logic all_done;
    logic scan_last;
    logic found;
    logic finishing;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/srtf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srtf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/srtf_ctrl.sv =====
// Sequencer of the SRTF scheduler: steps a tick through scan, update and result.
`default_nettype none

module srtf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_op_i,
  input  wire srtf_pkg::sts_t sts_i,
  output srtf_pkg::cmd_t      cmd_o,
  output logic                in_ready_o
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    DRAIN,
    DECIDE,
    PICK,
    UPDATE,
    FIN,
    RESULT
  } state_e;

  state_e state_q, state_d;
  logic   sums_q, sums_d;

  always_comb begin
    state_d    = state_q;
    sums_d     = 1'b0;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == srtf_pkg::OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = sts_i.all_done ? RESULT : SCAN;
          end
        end
      end
      SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = DRAIN;
        end
      end
      DRAIN:  state_d = DECIDE;
      DECIDE: state_d = sts_i.found ? PICK : RESULT;
      PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = UPDATE;
      end
      UPDATE: begin
        cmd_o.upd = 1'b1;
        state_d   = sts_i.finishing ? FIN : RESULT;
      end
      FIN: begin
        cmd_o.fin = 1'b1;
        sums_d    = 1'b1;
        state_d   = RESULT;
      end
      RESULT: begin
        // totals are grown before the output load is issued
        if (sums_q) begin
          cmd_o.sums = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      sums_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sums_q  <= sums_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/srtf_dp.sv =====
// Datapath of the SRTF scheduler: slot stores, scan compare, timing math, output register.
`default_nettype none

module srtf_dp #(
  parameter int MAX_PROCESSES = srtf_pkg::MAX_PROCESSES_DEF,
  parameter int TIME_BITS     = srtf_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire srtf_pkg::cmd_t                cmd_i,
  output srtf_pkg::sts_t                     sts_o,
  input  wire logic [srtf_pkg::PC_W-1:0]     pc_i,
  input  wire logic [srtf_pkg::SLOT_W-1:0]   slot_i,
  input  wire logic [TIME_BITS-1:0]          arrival_i,
  input  wire logic [TIME_BITS-1:0]          burst_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [srtf_pkg::NOW_W-1:0]         tick_time_o,
  output logic                               ran_o,
  output logic [srtf_pkg::CHOSEN_W-1:0]      chosen_o,
  output logic                               finished_o,
  output logic [srtf_pkg::NOW_W-1:0]         completion_o,
  output logic [srtf_pkg::NOW_W-1:0]         turnaround_o,
  output logic [srtf_pkg::NOW_W-1:0]         waiting_o,
  output logic [srtf_pkg::SUM_W-1:0]         total_waiting_o,
  output logic [srtf_pkg::SUM_W-1:0]         total_turnaround_o,
  output logic                               all_done_o
);

  localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int LIM_W = ($clog2(MAX_PROCESSES + 1) > srtf_pkg::PC_W) ?
                         $clog2(MAX_PROCESSES + 1) : srtf_pkg::PC_W;
  localparam int CMP_W = (TIME_BITS > srtf_pkg::NOW_W) ? TIME_BITS : srtf_pkg::NOW_W;
  localparam int NW    = srtf_pkg::NOW_W;
  localparam int SW    = srtf_pkg::SUM_W;

  // scheduler state
  logic [NW-1:0]                 now_q;
  logic [srtf_pkg::DONE_W-1:0]   done_q;
  logic [SW-1:0]                 wsum_q, tsum_q;
  logic [MAX_PROCESSES-1:0]      rem_vld_q;

  // per-tick working registers
  logic [IDX_W-1:0]     cnt_q, cmp_idx_q, pick_q;
  logic                 cmp_v_q, found_q, fin_q, sched_q;
  logic [TIME_BITS-1:0] best_q, bur_q;
  logic [NW-1:0]        comp_q, tat_q, wt_q;

  logic                 out_valid_q;

  // store ports
  logic [TIME_BITS-1:0] arr_rd, bur_rd, rem_rd;
  logic [IDX_W-1:0]     rd_addr, slot_idx, rem_waddr;
  logic [TIME_BITS-1:0] rem_wdata;
  logic                 ld_ok, rem_we;

  assign slot_idx  = IDX_W'(slot_i);
  assign ld_ok     = cmd_i.load && (32'(slot_i) < 32'(MAX_PROCESSES));
  assign rd_addr   = cmd_i.pick ? pick_q : cnt_q;
  assign rem_we    = ld_ok || cmd_i.upd;
  assign rem_waddr = cmd_i.upd ? pick_q : slot_idx;
  assign rem_wdata = cmd_i.upd ? (best_q - 1'b1) : burst_i;

  srtf_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_PROCESSES)) u_arr_ram (
    .clk_i   (clk_i),
    .we_i    (ld_ok),
    .waddr_i (slot_idx),
    .wdata_i (arrival_i),
    .raddr_i (rd_addr),
    .rdata_o (arr_rd)
  );

  srtf_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_PROCESSES)) u_bur_ram (
    .clk_i   (clk_i),
    .we_i    (ld_ok),
    .waddr_i (slot_idx),
    .wdata_i (burst_i),
    .raddr_i (rd_addr),
    .rdata_o (bur_rd)
  );

  srtf_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_PROCESSES)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rem_rd)
  );

  // scan range: min(process_count, MAX_PROCESSES)
  logic [LIM_W-1:0] pc_ext, max_ext, lim;
  logic [IDX_W-1:0] last_idx;
  assign pc_ext   = LIM_W'(pc_i);
  assign max_ext  = LIM_W'(MAX_PROCESSES);
  assign lim      = (pc_ext < max_ext) ? pc_ext : max_ext;
  assign last_idx = IDX_W'(lim - 1'b1);

  // compare stage, one slot per cycle behind the read
  logic [TIME_BITS-1:0] rem_eff;
  logic                 arrived, better;
  assign rem_eff = rem_vld_q[cmp_idx_q] ? rem_rd : '0;
  assign arrived = CMP_W'(arr_rd) <= CMP_W'(now_q);
  assign better  = cmp_v_q && arrived && (rem_eff != '0) && (!found_q || rem_eff < best_q);

  // timing arithmetic
  logic [CMP_W-1:0] comp_ext, arr_ext, tat_ext, bur_ext;
  logic [NW-1:0]    now_inc;
  logic [SW:0]      wsum_add, tsum_add;
  assign now_inc  = (now_q == srtf_pkg::NOW_MAX) ? srtf_pkg::NOW_MAX : now_q + 1'b1;
  assign comp_ext = CMP_W'(comp_q);
  assign arr_ext  = CMP_W'(arr_rd);
  assign tat_ext  = CMP_W'(tat_q);
  assign bur_ext  = CMP_W'(bur_q);
  assign wsum_add = {1'b0, wsum_q} + (SW + 1)'(wt_q);
  assign tsum_add = {1'b0, tsum_q} + (SW + 1)'(tat_q);

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      done_q      <= '0;
      wsum_q      <= '0;
      tsum_q      <= '0;
      rem_vld_q   <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cmp_v_q <= cmd_i.scan;
      if (ld_ok) begin
        rem_vld_q[slot_idx] <= 1'b1;
      end
      if (cmd_i.sums) begin
        wsum_q <= (wsum_add > (SW + 1)'(srtf_pkg::SUM_MAX)) ? srtf_pkg::SUM_MAX
                                                             : wsum_add[SW-1:0];
        tsum_q <= (tsum_add > (SW + 1)'(srtf_pkg::SUM_MAX)) ? srtf_pkg::SUM_MAX
                                                             : tsum_add[SW-1:0];
        done_q <= (done_q == srtf_pkg::DONE_MAX) ? srtf_pkg::DONE_MAX : done_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        if (sched_q) begin
          now_q <= now_inc;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cnt_q   <= '0;
      found_q <= 1'b0;
      fin_q   <= 1'b0;
      sched_q <= !sts_o.all_done;
      comp_q  <= now_inc;
    end else if (cmd_i.scan) begin
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.scan) begin
      cmp_idx_q <= cnt_q;
    end
    if (better) begin
      found_q <= 1'b1;
      best_q  <= rem_eff;
      pick_q  <= cmp_idx_q;
    end
    if (cmd_i.upd) begin
      fin_q <= (best_q == TIME_BITS'(1));
      bur_q <= bur_rd;
      tat_q <= NW'((comp_ext >= arr_ext) ? comp_ext - arr_ext : '0);
    end
    if (cmd_i.fin) begin
      wt_q <= NW'((tat_ext >= bur_ext) ? tat_ext - bur_ext : '0);
    end
    if (cmd_i.out_load) begin
      tick_time_o  <= now_q;
      ran_o        <= found_q;
      chosen_o     <= found_q ? srtf_pkg::CHOSEN_W'(pick_q) : '0;
      finished_o   <= fin_q;
      completion_o <= fin_q ? comp_q : '0;
      turnaround_o <= fin_q ? tat_q : '0;
      waiting_o    <= fin_q ? wt_q : '0;
      total_waiting_o    <= wsum_q;
      total_turnaround_o <= tsum_q;
      all_done_o   <= (done_q >= pc_i);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.all_done  = (done_q >= pc_i);
  assign sts_o.scan_last = (cnt_q == last_idx);
  assign sts_o.found     = found_q;
  assign sts_o.finishing = (best_q == TIME_BITS'(1));
  assign sts_o.out_free  = out_free;

endmodule

`default_nettype wire

// ===== hdl/srtf_preemptive_scheduler.sv =====
// Top level of the preemptive shortest-remaining-time-first scheduler.
//
// Input stream (s_axis): tuser carries the opcode. A load transaction
// writes one slot's arrival and burst, and the block stays idle and ready. A tick
// transaction scans the slots in use, runs the one with the least nonzero
// remaining time for one unit and returns exactly one result on m_axis.
// Loads return nothing.
// A tick steps through a scan of min(process_count, MAX_PROCESSES) slots,
// drain and decide; when a slot runs, pick and update follow, then finish
// and totals if it completes, and last the result load. Once all slots are
// done the tick goes straight to the result. The scan reads the slot RAMs
// one slot per cycle; a new transaction is taken the cycle after the result
// is loaded. A finished result waits in the output register while loads are
// taken; a following tick holds in its last step until the receiver takes
// the earlier result, and s_axis_tready stays low meanwhile. Reset clears
// time, totals, done count and the remaining-time valid bits; process_count
// returns to 1. Configuration is to be written over the APB port only while
// the block is idle (not enforced); register 0 (address 0) is process_count.
`default_nettype none

module srtf_preemptive_scheduler #(
  parameter int MAX_PROCESSES = srtf_pkg::MAX_PROCESSES_DEF,
  parameter int TIME_BITS     = srtf_pkg::TIME_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // APB configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [2:0]                         paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready,
  // input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // slot, arrival, burst, zero pad
  input  wire logic [((srtf_pkg::SLOT_W + 2 * TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // opcode
  input  wire logic [0:0]                         s_axis_tuser,
  // output stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tick_time, chosen, completion, turnaround, waiting, total_waiting,
  // total_turnaround, all_done, zero pad
  output logic [srtf_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // ran, finished
  output logic [1:0]                              m_axis_tuser
);

  localparam int SW_ = srtf_pkg::SLOT_W;
  localparam int NW  = srtf_pkg::NOW_W;
  localparam int SMW = srtf_pkg::SUM_W;

  // configuration register
  logic [srtf_pkg::PC_W-1:0] pc_q;
  logic                      reg_sel;
  assign reg_sel = (paddr[2] == srtf_pkg::REG_PROCESS_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(pc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= srtf_pkg::PC_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      pc_q <= pwdata[srtf_pkg::PC_W-1:0];
    end
  end

  srtf_pkg::cmd_t cmd;
  srtf_pkg::sts_t sts;

  srtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser[0]),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  logic [NW-1:0]                    tick_time, completion, turnaround, waiting;
  logic [SMW-1:0]                   total_waiting, total_turnaround;
  logic [srtf_pkg::CHOSEN_W-1:0]    chosen;
  logic                             ran, finished, all_done;

  srtf_dp #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .TIME_BITS     (TIME_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .pc_i               (pc_q),
    .slot_i             (s_axis_tdata[SW_-1:0]),
    .arrival_i          (s_axis_tdata[SW_ + TIME_BITS - 1:SW_]),
    .burst_i            (s_axis_tdata[SW_ + 2 * TIME_BITS - 1:SW_ + TIME_BITS]),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .tick_time_o        (tick_time),
    .ran_o              (ran),
    .chosen_o           (chosen),
    .finished_o         (finished),
    .completion_o       (completion),
    .turnaround_o       (turnaround),
    .waiting_o          (waiting),
    .total_waiting_o    (total_waiting),
    .total_turnaround_o (total_turnaround),
    .all_done_o         (all_done)
  );

  assign m_axis_tdata = {{(srtf_pkg::OUT_DATA_W - srtf_pkg::OUT_FIELDS_W){1'b0}},
                         all_done, total_turnaround, total_waiting, waiting,
                         turnaround, completion, chosen, tick_time};
  assign m_axis_tuser = {finished, ran};

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the preemptive SRTF scheduler.
`timescale 1ns / 1ps

module tb;
  import srtf_pkg::*;

  localparam int MAX_SLOTS   = MAX_PROCESSES_DEF;
  localparam int TIME_W      = TIME_BITS_DEF;
  localparam int IN_DATA_W   = ((SLOT_W + 2 * TIME_W + 7) / 8) * 8;
  localparam int IDLE_PCT    = 13;
  localparam int SETTLE_CYC  = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] PC_ADDR = 3'(4 * int'(REG_PROCESS_COUNT));

  // result fields, last member (tick_time) in the lowest bits
  typedef struct packed {
    logic             all_done;
    logic [SUM_W-1:0] total_turnaround;
    logic [SUM_W-1:0] total_waiting;
    logic [NOW_W-1:0] waiting;
    logic [NOW_W-1:0] turnaround;
    logic [NOW_W-1:0] completion;
    logic [CHOSEN_W-1:0] chosen;
    logic [NOW_W-1:0] tick_time;
  } out_fields_t;

  typedef struct packed {
    logic        finished;
    logic        ran;
    out_fields_t f;
  } tick_report_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;   // slot, arrival, burst, zero pad
  logic [0:0]           s_axis_tuser;   // opcode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // tick_time, chosen, completion, turnaround,
                                        // waiting, total_waiting, total_turnaround,
                                        // all_done, zero pad
  logic [1:0]            m_axis_tuser;  // ran, finished

  srtf_preemptive_scheduler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // scheduler mirror
  logic [TIME_W-1:0] arrival_tbl [MAX_SLOTS];
  logic [TIME_W-1:0] burst_tbl   [MAX_SLOTS];
  logic [TIME_W-1:0] remain_tbl  [MAX_SLOTS];
  logic [NOW_W-1:0]  now_t;
  logic [DONE_W-1:0] done_cnt;
  logic [SUM_W-1:0]  wait_total;
  logic [SUM_W-1:0]  tat_total;
  logic [PC_W-1:0]   proc_count;

  tick_report_t tick_reports[$];

  int  mismatches;
  int  cycle_count;
  int  loads_sent, ticks_sent, completions_seen, done_reports_seen, count_settings;
  bit  calm;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d reports still pending", $time, tick_reports.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (calm) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                               input logic [NOW_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + b;
    return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic void store_process(input logic [SLOT_W-1:0] slot,
                                        input logic [TIME_W-1:0] arrival,
                                        input logic [TIME_W-1:0] burst);
    arrival_tbl[slot] = arrival;
    burst_tbl[slot]   = burst;
    remain_tbl[slot]  = burst;
  endfunction

  function automatic tick_report_t schedule_tick();
    tick_report_t     rep;
    int               limit;
    int               pick;
    logic             found;
    logic [TIME_W-1:0] best;
    logic [NOW_W-1:0] comp, tat, wt;
    rep   = '0;
    found = 1'b0;
    pick  = 0;
    best  = '0;
    rep.f.tick_time = now_t;
    if (done_cnt < proc_count) begin
      limit = (proc_count < MAX_SLOTS) ? int'(proc_count) : MAX_SLOTS;
      for (int i = 0; i < limit; i++) begin
        if (arrival_tbl[i] <= now_t && remain_tbl[i] != 0 && (!found || remain_tbl[i] < best)) begin
          best  = remain_tbl[i];
          pick  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        rep.ran      = 1'b1;
        rep.f.chosen = CHOSEN_W'(pick);
        remain_tbl[pick] = remain_tbl[pick] - 1'b1;
        if (remain_tbl[pick] == 0) begin
          comp = (now_t == NOW_MAX) ? NOW_MAX : now_t + 1'b1;
          tat  = (comp >= arrival_tbl[pick]) ? comp - arrival_tbl[pick] : '0;
          wt   = (tat >= burst_tbl[pick]) ? tat - burst_tbl[pick] : '0;
          done_cnt   = (done_cnt == DONE_MAX) ? DONE_MAX : done_cnt + 1'b1;
          wait_total = sat_sum(wait_total, wt);
          tat_total  = sat_sum(tat_total, tat);
          rep.finished     = 1'b1;
          rep.f.completion = comp;
          rep.f.turnaround = tat;
          rep.f.waiting    = wt;
        end
      end
      if (now_t != NOW_MAX) now_t = now_t + 1'b1;
    end
    rep.f.total_waiting    = wait_total;
    rep.f.total_turnaround = tat_total;
    rep.f.all_done         = (done_cnt >= proc_count);
    return rep;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    tick_report_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ran      = m_axis_tuser[0];
      got.finished = m_axis_tuser[1];
      got.f        = m_axis_tdata[$bits(out_fields_t)-1:0];
      if (tick_reports.size() == 0) begin
        $display("%0t ns: result with nothing expected, tick_time %0d", $time, got.f.tick_time);
        mismatches++;
      end else begin
        want = tick_reports.pop_front();
        compare_field("ran", want.ran, got.ran);
        compare_field("finished", want.finished, got.finished);
        compare_field("tick_time", want.f.tick_time, got.f.tick_time);
        compare_field("chosen", want.f.chosen, got.f.chosen);
        compare_field("completion", want.f.completion, got.f.completion);
        compare_field("turnaround", want.f.turnaround, got.f.turnaround);
        compare_field("waiting", want.f.waiting, got.f.waiting);
        compare_field("total_waiting", want.f.total_waiting, got.f.total_waiting);
        compare_field("total_turnaround", want.f.total_turnaround, got.f.total_turnaround);
        compare_field("all_done", want.f.all_done, got.f.all_done);
      end
      if (got.finished) completions_seen++;
      if (got.f.all_done) done_reports_seen++;
    end
  end

  task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                           input logic [TIME_W-1:0] arrival, input logic [TIME_W-1:0] burst);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DATA_W'({burst, arrival, slot});
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_LOAD) begin
      store_process(slot, arrival, burst);
      loads_sent++;
    end else begin
      tick_reports.push_back(schedule_tick());
      ticks_sent++;
    end
  endtask

  // drop valid and let the scheduler drain before touching configuration
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tick_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_process_count(input logic [PC_W-1:0] value);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PC_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[PC_W-1:0] !== value) begin
      $display("%0t ns: process_count readback, expected %0d, actual %0d",
               $time, value, rd[PC_W-1:0]);
      mismatches++;
    end
  endtask

  task automatic set_process_count(input logic [PC_W-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PC_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    proc_count = value;
    count_settings++;
    @(negedge clk_i);
    check_process_count(value);
  endtask

  task automatic test_reset_value();
    @(negedge clk_i);
    check_process_count(PC_RESET);
  endtask

  // every slot gets written up front, so no scan ever reads an empty entry
  task automatic test_load_table();
    send_item(OP_LOAD, 4'd0, 16'd0, 16'd1);
    send_item(OP_LOAD, 4'd1, 16'd0, 16'd3);
    send_item(OP_LOAD, 4'd2, 16'd2, 16'd2);
    send_item(OP_LOAD, 4'd3, 16'd0, 16'd3);         // ties with slot 1
    send_item(OP_LOAD, 4'd4, 16'hFFFF, 16'hFFFF);   // never arrives
    send_item(OP_LOAD, 4'd5, 16'd0, 16'd0);         // zero burst, never runs
    for (int s = 6; s < MAX_SLOTS; s++)
      send_item(OP_LOAD, SLOT_W'(s), 16'($urandom_range(0, 20)), 16'($urandom_range(2, 30)));
  endtask

  task automatic test_single_slot();
    send_item(OP_TICK, '0, '0, '0);
    send_item(OP_TICK, '1, '1, '1);                 // all done, time holds
    send_item(OP_LOAD, 4'd0, 16'd0, 16'd2);         // load after done leaves the count alone
    send_item(OP_TICK, '0, '0, '0);
  endtask

  task automatic test_zero_count();
    set_process_count(5'd0);
    send_item(OP_TICK, '0, '0, '0);
  endtask

  task automatic test_preemption();
    set_process_count(5'd4);
    repeat (3) send_item(OP_TICK, '0, '0, '0);
    send_item(OP_LOAD, 4'd3, now_t[TIME_W-1:0], 16'd1);  // shortest job jumps ahead
    repeat (3) send_item(OP_TICK, '0, '0, '0);
  endtask

  task automatic test_wide_counts();
    set_process_count(5'(MAX_SLOTS));
    repeat (2) send_item(OP_TICK, '0, '0, '0);
    set_process_count(DONE_MAX);
    repeat (2) send_item(OP_TICK, '0, '0, '0);
  endtask

  task automatic test_random_schedule(input int n_items);
    int                sent, phase, span, top;
    logic [PC_W-1:0]   count;
    logic [TIME_W-1:0] burst;
    sent  = 0;
    phase = 0;
    while (sent < n_items) begin
      if (done_cnt < DONE_MAX && $urandom_range(0, 3) != 0)
        count = PC_W'($urandom_range(int'(done_cnt) + 1, int'(DONE_MAX)));
      else
        count = PC_W'($urandom_range(0, int'(DONE_MAX)));
      set_process_count(count);
      calm = (phase == 3 || phase == 4);
      span = $urandom_range(30, 60);
      top  = (count == 0) ? 0 : ((count < MAX_SLOTS) ? int'(count) - 1 : MAX_SLOTS - 1);
      repeat (span) begin
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(OP_LOAD, SLOT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
          end else begin
            // completions are scarce once done_count nears saturation, so stretch jobs
            burst = (done_cnt < 20) ? TIME_W'($urandom_range(1, 24))
                                    : TIME_W'($urandom_range(16, 120));
            send_item(OP_LOAD, SLOT_W'($urandom_range(0, top)),
                      now_t[TIME_W-1:0] + TIME_W'($urandom_range(0, 6)), burst);
          end
        end else begin
          send_item(OP_TICK, SLOT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
        end
        sent++;
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    m_axis_tready = 1'b0;
    calm          = 1'b0;
    mismatches    = 0;
    cycle_count   = 0;
    loads_sent = 0; ticks_sent = 0; completions_seen = 0;
    done_reports_seen = 0; count_settings = 0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      arrival_tbl[i] = '0;
      burst_tbl[i]   = '0;
      remain_tbl[i]  = '0;
    end
    now_t      = '0;
    done_cnt   = '0;
    wait_total = '0;
    tat_total  = '0;
    proc_count = PC_RESET;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_value();
    test_load_table();
    test_single_slot();
    test_zero_count();
    test_preemption();
    test_wide_counts();
    test_random_schedule(450);

    wait_idle();
    $display("Ran %0d loads and %0d ticks over %0d process_count settings;",
             loads_sent, ticks_sent, count_settings);
    $display("saw %0d completions and %0d all-done reports, %0d mismatches.",
             completions_seen, done_reports_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== srtf_preemptive_scheduler.f =====
hdl/srtf_pkg.sv
hdl/srtf_ram.sv
hdl/srtf_ctrl.sv
hdl/srtf_dp.sv
hdl/srtf_preemptive_scheduler.sv
tb/tb.sv
